FILE: hdl/xpp_pkg.sv
// Shared types, constants and register codes for the XNOR-popcount pooling neuron.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package xpp_pkg;

    localparam int WORD_BITS     = 32;
    localparam int MAX_DOT_WORDS = 256;

    // dot_words is a 9-bit register, so the effective cap never exceeds 511
    localparam int DOT_WORDS_CAP = (MAX_DOT_WORDS < 511) ? MAX_DOT_WORDS : 511;
    localparam int POOL_CAP      = 7;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;

    localparam int ACC_W    = 16;
    localparam int MATCH_W  = 7;
    localparam int THRESH_W = 32;
    localparam int SCALE_SHIFT = 6;   // times 64

    localparam logic [31:0] MASK_PAIRS   = 32'h5555_5555;
    localparam logic [31:0] MASK_NIBBLES = 32'h3333_3333;
    localparam logic [31:0] MASK_BYTES   = 32'h0F0F_0F0F;

    localparam logic signed [ACC_W-1:0] POOL_MAX_RESET = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DOT_WORDS     = 2'd0,
        REG_POOL_WINDOW   = 2'd1,
        REG_BITS_PER_WORD = 2'd2,
        REG_POLARITY      = 2'd3
    } cfg_index_t;

    // effective (clamped) register values
    typedef struct packed {
        logic [8:0] dot_words;
        logic [2:0] pool_window;
        logic [5:0] bits_per_word;
        logic       polarity;
    } cfg_t;

    typedef struct packed {
        logic                   emit;
        logic [WORD_BITS-1:0]   word;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/xpp_cfg_regs.sv
// Configuration register bank with range clamping of the stored values.
// Depends on xpp_pkg for register codes, widths and the cfg_t struct.
`default_nettype none

module xpp_cfg_regs (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               wr_en,
    input  wire logic [xpp_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  wire logic [xpp_pkg::CFG_DATA_W-1:0]     wr_data,
    output xpp_pkg::cfg_t                           cfg
);

    logic [8:0] dot_words_reg;
    logic [2:0] pool_window_reg;
    logic [5:0] bits_per_word_reg;
    logic       polarity_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_words_reg     <= 9'd9;
            pool_window_reg   <= 3'd4;
            bits_per_word_reg <= 6'd32;
            polarity_reg      <= 1'b0;
        end else if (wr_en) begin
            unique case (xpp_pkg::cfg_index_t'(wr_index))
                xpp_pkg::REG_DOT_WORDS:     dot_words_reg     <= wr_data[8:0];
                xpp_pkg::REG_POOL_WINDOW:   pool_window_reg   <= wr_data[2:0];
                xpp_pkg::REG_BITS_PER_WORD: bits_per_word_reg <= wr_data[5:0];
                xpp_pkg::REG_POLARITY:      polarity_reg      <= wr_data[0];
                default: ;
            endcase
        end
    end

    // zero acts as one; oversize values saturate at the cap
    always_comb begin
        if (dot_words_reg == 9'd0) begin
            cfg.dot_words = 9'd1;
        end else if (dot_words_reg > 9'(xpp_pkg::DOT_WORDS_CAP)) begin
            cfg.dot_words = 9'(xpp_pkg::DOT_WORDS_CAP);
        end else begin
            cfg.dot_words = dot_words_reg;
        end

        cfg.pool_window = (pool_window_reg == 3'd0) ? 3'd1 : pool_window_reg;

        if (bits_per_word_reg == 6'd0) begin
            cfg.bits_per_word = 6'd1;
        end else if (bits_per_word_reg > 6'(xpp_pkg::WORD_BITS)) begin
            cfg.bits_per_word = 6'(xpp_pkg::WORD_BITS);
        end else begin
            cfg.bits_per_word = bits_per_word_reg;
        end

        cfg.polarity = polarity_reg;
    end

endmodule

`default_nettype wire

FILE: hdl/xpp_match.sv
// XNOR match score of a feature and weight word: word width minus twice the XOR popcount.
// Depends on xpp_pkg for the word width and the popcount masks.
`default_nettype none

module xpp_match (
    input  wire logic [xpp_pkg::WORD_BITS-1:0]          feature_word,
    input  wire logic [xpp_pkg::WORD_BITS-1:0]          weight_word,
    output logic signed [xpp_pkg::MATCH_W-1:0]          match
);

    logic [31:0] diff;
    logic [31:0] pairs;
    logic [31:0] nibbles;
    logic [31:0] bytes_cnt;
    logic [5:0]  ones;

    always_comb begin
        diff      = feature_word ^ weight_word;
        pairs     = diff - ((diff >> 1) & xpp_pkg::MASK_PAIRS);
        nibbles   = (pairs & xpp_pkg::MASK_NIBBLES) + ((pairs >> 2) & xpp_pkg::MASK_NIBBLES);
        bytes_cnt = (nibbles + (nibbles >> 4)) & xpp_pkg::MASK_BYTES;
        // add the four byte counts rather than multiply
        ones      = 6'(bytes_cnt[7:0]) + 6'(bytes_cnt[15:8])
                  + 6'(bytes_cnt[23:16]) + 6'(bytes_cnt[31:24]);
        match     = $signed(7'(xpp_pkg::WORD_BITS) - {ones, 1'b0});
    end

endmodule

`default_nettype wire

FILE: hdl/xpp_neuron.sv
// Neuron state: dot accumulation, max pooling, threshold compare and bit packing.
// Depends on xpp_pkg for widths, cfg_t and result_t.
`default_nettype none

module xpp_neuron (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   step,
    input  wire logic signed [xpp_pkg::MATCH_W-1:0]     match,
    input  wire logic signed [xpp_pkg::THRESH_W-1:0]    threshold,
    input  wire xpp_pkg::cfg_t                          cfg,
    output xpp_pkg::result_t                            res
);

    logic signed [xpp_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic signed [xpp_pkg::ACC_W-1:0]   max_reg, max_next;
    logic [8:0]                         word_cnt_reg, word_cnt_next;
    logic [2:0]                         pool_cnt_reg, pool_cnt_next;
    logic [5:0]                         bit_cnt_reg, bit_cnt_next;
    logic [xpp_pkg::WORD_BITS-1:0]      packed_reg, packed_next;

    logic signed [xpp_pkg::ACC_W-1:0]   acc_sum;
    logic signed [xpp_pkg::ACC_W-1:0]   max_cand;
    logic signed [xpp_pkg::THRESH_W-1:0] scaled;
    logic                               word_done;
    logic                               pool_done;
    logic                               bit_done;
    logic                               at_or_above;
    logic                               set_bit;
    logic [xpp_pkg::WORD_BITS-1:0]      bits_new;

    always_comb begin
        acc_sum   = acc_reg + xpp_pkg::ACC_W'(match);
        word_done = ({1'b0, word_cnt_reg} + 10'd1) >= {1'b0, cfg.dot_words};
        pool_done = ({1'b0, pool_cnt_reg} + 4'd1) >= {1'b0, cfg.pool_window};
        bit_done  = ({1'b0, bit_cnt_reg} + 7'd1) >= {1'b0, cfg.bits_per_word};
        max_cand  = (acc_sum > max_reg) ? acc_sum : max_reg;
        scaled    = $signed({{(xpp_pkg::THRESH_W - xpp_pkg::ACC_W - xpp_pkg::SCALE_SHIFT)
                              {max_cand[xpp_pkg::ACC_W-1]}},
                             max_cand, {xpp_pkg::SCALE_SHIFT{1'b0}}});
        at_or_above = scaled >= threshold;
        set_bit   = cfg.polarity ? at_or_above : !at_or_above;
        bits_new  = packed_reg | (xpp_pkg::WORD_BITS'(set_bit) << bit_cnt_reg[4:0]);

        acc_next      = acc_reg;
        max_next      = max_reg;
        word_cnt_next = word_cnt_reg;
        pool_cnt_next = pool_cnt_reg;
        bit_cnt_next  = bit_cnt_reg;
        packed_next   = packed_reg;
        // a step taken now would close a packed word
        res.emit      = word_done && pool_done && bit_done;
        res.word      = bits_new;

        if (step) begin
            if (!word_done) begin
                acc_next      = acc_sum;
                word_cnt_next = word_cnt_reg + 9'd1;
            end else begin
                acc_next      = '0;
                word_cnt_next = '0;
                if (!pool_done) begin
                    max_next      = max_cand;
                    pool_cnt_next = pool_cnt_reg + 3'd1;
                end else begin
                    max_next      = xpp_pkg::POOL_MAX_RESET;
                    pool_cnt_next = '0;
                    if (!bit_done) begin
                        bit_cnt_next = bit_cnt_reg + 6'd1;
                        packed_next  = bits_new;
                    end else begin
                        bit_cnt_next = '0;
                        packed_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            max_reg      <= xpp_pkg::POOL_MAX_RESET;
            word_cnt_reg <= '0;
            pool_cnt_reg <= '0;
            bit_cnt_reg  <= '0;
            packed_reg   <= '0;
        end else begin
            acc_reg      <= acc_next;
            max_reg      <= max_next;
            word_cnt_reg <= word_cnt_next;
            pool_cnt_reg <= pool_cnt_next;
            bit_cnt_reg  <= bit_cnt_next;
            packed_reg   <= packed_next;
        end
    end

    // a fresh dot product always starts from an empty accumulator
    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (word_cnt_reg == 9'd0) |-> (acc_reg == '0))
        else $error("accumulator not clear at start of dot product");

    // a fresh pool group always starts from the most negative maximum
    a_max_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pool_cnt_reg == 3'd0) |-> (max_reg == xpp_pkg::POOL_MAX_RESET))
        else $error("pool maximum not reset at start of group");

    // emit is raised only when a dot product, a pool group and a packed word all close together
    a_emit_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        res.emit |-> (word_done && pool_done && bit_done))
        else $error("word emitted without completing a group");

    // emitting a word empties the packing register
    a_emit_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && res.emit) |=> (packed_reg == '0 && bit_cnt_reg == 6'd0))
        else $error("packing state not cleared after emit");

endmodule

`default_nettype wire

FILE: hdl/xnor_popcount_pool_binarize_core.sv
// Top level of the binarized neuron engine: stream ports, input and result registers.
// Depends on xpp_pkg, xpp_cfg_regs, xpp_match and xpp_neuron.
`default_nettype none

// One request per cycle is taken while the input side does not stall: each feature/weight
// word pair is latched in an input register, then scored and folded into the neuron state in
// the following cycle unless stalled, and the word closed by a request is latched in the result
// register before it is presented on the master side. Every
// dot_words requests close a dot product, every pool_window dot products close a max-pool
// group and produce one threshold bit (the threshold of the closing request is used), and
// every bits_per_word bits one packed activation word is presented on the master side. The
// input side stalls only when a word is ready to leave while the previous one is still held.
// Configuration writes are always accepted and must be issued while the stream is idle.

module xnor_popcount_pool_binarize_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // s_tdata: [31:0] feature_word, [63:32] weight_word, [95:64] threshold
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [95:0]                        s_tdata,

    // m_tdata: [31:0] activation_word
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [31:0]                             m_tdata,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [xpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [xpp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    xpp_pkg::cfg_t      cfg;
    xpp_pkg::result_t   res;

    logic                                   in_valid_reg, in_valid_next;
    logic [xpp_pkg::WORD_BITS-1:0]          feature_reg;
    logic [xpp_pkg::WORD_BITS-1:0]          weight_reg;
    logic signed [xpp_pkg::THRESH_W-1:0]    threshold_reg;
    logic                                   out_valid_reg, out_valid_next;
    logic [xpp_pkg::WORD_BITS-1:0]          out_data_reg;

    logic signed [xpp_pkg::MATCH_W-1:0]     match;
    logic                                   step;
    logic                                   s_accept;

    assign cfg_ready = 1'b1;

    xpp_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    xpp_match u_match (
        .feature_word (feature_reg),
        .weight_word  (weight_reg),
        .match        (match)
    );

    xpp_neuron u_neuron (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .match     (match),
        .threshold (threshold_reg),
        .cfg       (cfg),
        .res       (res)
    );

    // hold the latched request only while its word cannot enter the result register
    always_comb begin
        step     = in_valid_reg && (!res.emit || !out_valid_reg || m_tready);
        s_tready = !in_valid_reg || step;
        s_accept = s_tvalid && s_tready;

        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (step && res.emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            feature_reg   <= s_tdata[31:0];
            weight_reg    <= s_tdata[63:32];
            threshold_reg <= $signed(s_tdata[95:64]);
        end
        if (step && res.emit) begin
            out_data_reg <= res.word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

FILE: tb/xnor_popcount_pool_binarize_core_test.sv
// Self-checking bench for xnor_popcount_pool_binarize_core: directed and random requests,
// checked against an in-bench prediction of the packed activation words.
// Depends on xpp_pkg and the core RTL only.
`default_nettype none

module xnor_popcount_pool_binarize_core_test;

    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYCLES = 10;

    // Tracks dot, pool and packing state; holds the activation words still to arrive.
    class activation_predictor;
        logic [8:0] dot_words;
        logic [2:0] pool_window;
        logic [5:0] bits_per_word;
        logic       polarity;
        shortint    dot_sum;
        shortint    pool_max;
        logic [8:0] word_cnt;
        logic [2:0] pool_cnt;
        logic [5:0] bit_cnt;
        logic [31:0] packed_bits;
        logic [31:0] pending_words[$];
        int          mismatches;

        function new();
            dot_words = 9'd9;
            pool_window = 3'd4;
            bits_per_word = 6'd32;
            polarity = 1'b0;
            dot_sum = 0;
            pool_max = -32768;
            word_cnt = '0;
            pool_cnt = '0;
            bit_cnt = '0;
            packed_bits = '0;
            mismatches = 0;
        endfunction

        function int unsigned limit_of(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void apply_register(xpp_pkg::cfg_index_t idx, logic [8:0] val);
            case (idx)
                xpp_pkg::REG_DOT_WORDS:     dot_words = val;
                xpp_pkg::REG_POOL_WINDOW:   pool_window = val[2:0];
                xpp_pkg::REG_BITS_PER_WORD: bits_per_word = val[5:0];
                xpp_pkg::REG_POLARITY:      polarity = val[0];
                default: ;
            endcase
        endfunction

        function shortint match_of(logic [31:0] fw, logic [31:0] ww);
            return shortint'(32 - 2 * $countones(fw ^ ww));
        endfunction

        // Scaled pool maximum if this request were to close the group
        function longint projected_scaled(logic [31:0] fw, logic [31:0] ww);
            shortint sum;
            sum = dot_sum + match_of(fw, ww);
            if (pool_max > sum) sum = pool_max;
            return longint'(sum) * 64;
        endfunction

        function void note_request(logic [31:0] fw, logic [31:0] ww, logic signed [31:0] thr);
            int unsigned dw;
            int unsigned pw;
            int unsigned bw;
            longint      scaled;
            bit          at_or_above;
            dw = limit_of(dot_words, xpp_pkg::MAX_DOT_WORDS);
            pw = limit_of(pool_window, xpp_pkg::POOL_CAP);
            bw = limit_of(bits_per_word, xpp_pkg::WORD_BITS);
            dot_sum = dot_sum + match_of(fw, ww);
            if (word_cnt + 1 < dw) begin
                word_cnt = word_cnt + 1'b1;
                return;
            end
            word_cnt = '0;
            if (dot_sum > pool_max) pool_max = dot_sum;
            dot_sum = 0;
            if (pool_cnt + 1 < pw) begin
                pool_cnt = pool_cnt + 1'b1;
                return;
            end
            pool_cnt = '0;
            scaled = longint'(pool_max) * 64;
            at_or_above = scaled >= longint'(thr);
            if (polarity ? at_or_above : !at_or_above) packed_bits[bit_cnt[4:0]] = 1'b1;
            pool_max = -32768;
            if (bit_cnt + 1 < bw) begin
                bit_cnt = bit_cnt + 1'b1;
                return;
            end
            pending_words.push_back(packed_bits);
            packed_bits = '0;
            bit_cnt = '0;
        endfunction

        function void flag(string what, logic [31:0] want, logic [31:0] got);
            if (mismatches < 10)
                $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
            mismatches++;
        endfunction

        function void check_word(logic [31:0] got);
            logic [31:0] want;
            if (pending_words.size() == 0) begin
                flag("activation word with none pending", 'x, got);
                return;
            end
            want = pending_words.pop_front();
            if (want !== got) flag("activation word mismatch", want, got);
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [95:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    xpp_pkg::cfg_index_t  cfg_index = xpp_pkg::REG_DOT_WORDS;
    logic [8:0]           cfg_data = '0;

    bit                   tail_quiet = 1'b0;
    int                   quiet_cycles = 0;

    activation_predictor  predictor = new();

    // feature_word, weight_word, threshold
    logic [31:0] equality_set [12][3] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0800},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0801},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF},
        '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_F800},
        '{32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h0000_07FF},
        '{32'h0000_0000, 32'h0000_0001, 32'h0000_0781},
        '{32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_F801},
        '{32'h1234_5678, 32'h1234_5670, 32'h0000_0780},
        '{32'h8000_0000, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000},
        '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_0001}
    };

    logic [31:0] single_bit_set [8][3] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h8000_0000},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0800},
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0801},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_F800},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_F801},
        '{32'h00FF_00FF, 32'h0000_0000, 32'h0000_0000},
        '{32'h00FF_00FF, 32'h0000_0000, 32'h0000_0001}
    };

    xnor_popcount_pool_binarize_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) predictor.check_word(m_tdata);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: stall in bursts, none once the tail starts
    initial begin
        @(posedge aclk);
        forever begin
            if (!tail_quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    task automatic send_request(input logic [31:0] fw, ww, thr);
        s_tdata <= {thr, ww, fw};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predictor.note_request(fw, ww, thr);
    endtask

    task automatic maybe_idle_sender();
        if (!tail_quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    // Hold off requests until every pending word has arrived and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (predictor.pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input xpp_pkg::cfg_index_t idx, input logic [8:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        predictor.apply_register(idx, val);
    endtask

    task automatic program_regs(input logic [8:0] dw, pw, bw, pol);
        write_register(xpp_pkg::REG_DOT_WORDS, dw);
        write_register(xpp_pkg::REG_POOL_WINDOW, pw);
        write_register(xpp_pkg::REG_BITS_PER_WORD, bw);
        write_register(xpp_pkg::REG_POLARITY, pol);
        cfg_valid <= 1'b0;
    endtask

    task automatic make_request(output logic [31:0] fw, ww, thr);
        int unsigned kind;
        int unsigned pick;
        longint      level;
        fw = $urandom;
        kind = $urandom_range(0, 9);
        if (kind == 0) ww = fw;
        else if (kind == 1) ww = ~fw;
        else if (kind < 6) ww = $urandom;
        else ww = fw ^ ($urandom & $urandom & $urandom);
        level = predictor.projected_scaled(fw, ww);
        pick = $urandom_range(0, 9);
        if (pick == 0) thr = 32'h8000_0000;
        else if (pick == 1) thr = 32'h7FFF_FFFF;
        else if (pick < 5) thr = $urandom;
        else if (pick < 8) thr = 32'(level + int'($urandom_range(0, 2)) - 1);
        else thr = 32'(level + int'($urandom_range(0, 4096)) - 2048);
    endtask

    task automatic run_phase(input logic [8:0] dw, pw, bw, pol, input int count,
                             input bit pause_mid);
        logic [31:0] fw;
        logic [31:0] ww;
        logic [31:0] thr;
        settle();
        program_regs(dw, pw, bw, pol);
        for (int i = 0; i < count; i++) begin
            if (pause_mid && i == count / 2) settle();
            make_request(fw, ww, thr);
            send_request(fw, ww, thr);
            maybe_idle_sender();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Dense layer, four bits per word: threshold equality and extremes
        program_regs(9'd1, 9'd1, 9'd4, 9'd0);
        foreach (equality_set[i]) begin
            send_request(equality_set[i][0], equality_set[i][1], equality_set[i][2]);
            maybe_idle_sender();
        end
        // Zero in the dot, pool and bit-count registers acts as one: each request yields a word
        settle();
        program_regs(9'd0, 9'd0, 9'd0, 9'd1);
        foreach (single_bit_set[i]) begin
            send_request(single_bit_set[i][0], single_bit_set[i][1], single_bit_set[i][2]);
            maybe_idle_sender();
        end

        run_phase(9'd2, 9'd1, 9'd8, 9'd0, 200, 1'b0);
        run_phase(9'd1, 9'd2, 9'd3, 9'd1, 150, 1'b1);
        run_phase(9'd3, 9'd3, 9'd5, 9'd0, 250, 1'b0);
        run_phase(9'd256, 9'd1, 9'd1, 9'd1, 300, 1'b0);
        run_phase(9'd511, 9'd1, 9'd1, 9'd0, 260, 1'b0);
        run_phase(9'd1, 9'd7, 9'd1, 9'd1, 70, 1'b0);
        run_phase(9'd1, 9'd5, 9'd2, 9'd0, 60, 1'b0);
        run_phase(9'd1, 9'd1, 9'd32, 9'd1, 160, 1'b0);
        run_phase(9'd1, 9'd1, 9'd63, 9'd0, 96, 1'b0);
        run_phase(9'd4, 9'd4, 9'd2, 9'd1, 160, 1'b0);
        tail_quiet = 1'b1;
        run_phase(9'd2, 9'd1, 9'd6, 9'd0, 150, 1'b0);

        settle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (predictor.mismatches == 0 && predictor.pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
hdl/xpp_pkg.sv
hdl/xpp_cfg_regs.sv
hdl/xpp_match.sv
hdl/xpp_neuron.sv
hdl/xnor_popcount_pool_binarize_core.sv
tb/xnor_popcount_pool_binarize_core_test.sv
